// File: hw/rtl/wbps_pkg.sv
// ---------------------------------------------------------------------------
// wbps_pkg: shared types and constants of the wildcard byte pattern scanner
// Sizes of the window, offset counter and result queue, the record layout
// and helpers that pick pattern bytes and wildcard bits out of the registers.
// ---------------------------------------------------------------------------
package wbps_pkg;

	localparam int PATTERN_MAX = 16;
	localparam int OFFSET_BITS = 32;
	localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
	localparam int RQ_DEPTH    = 4;
	localparam int RQ_PTR_W    = $clog2(RQ_DEPTH);
	localparam int RQ_CNT_W    = $clog2(RQ_DEPTH + 1);

	// configuration register indexes
	localparam logic [7:0] REG_PAT_LOW  = 8'd0;
	localparam logic [7:0] REG_PAT_HIGH = 8'd1;
	localparam logic [7:0] REG_WILD     = 8'd2;
	localparam logic [7:0] REG_LEN      = 8'd3;

	// record kinds
	localparam logic KIND_MATCH   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [31:0] offset;
		logic [31:0] total;
		logic        last;
	} rec_t;

	// records produced by one input byte, first in rec0
	typedef struct packed {
		logic [1:0] cnt;
		rec_t       rec0;
		rec_t       rec1;
	} push_t;

	// pattern byte k, zero beyond the sixteen register bytes
	function automatic logic [7:0] pat_byte(input logic [63:0] lo, input logic [63:0] hi,
	                                        input int k);
		logic [127:0] all;
		all = {hi, lo};
		if (k >= 0 && k < 16) begin
			return all[k*8 +: 8];
		end
		return 8'd0;
	endfunction

	// wildcard bit k, never set beyond the sixteen mask bits
	function automatic logic pat_wild(input logic [15:0] mask, input int k);
		if (k >= 0 && k < 16) begin
			return mask[k];
		end
		return 1'b0;
	endfunction

endpackage

// File: hw/rtl/wbps_cell.sv
// ---------------------------------------------------------------------------
// wbps_cell: one window cell of the scanner
// Holds one byte of the recent-byte window, passes it on to the next cell
// and compares the byte it takes in against its pattern byte.
// ---------------------------------------------------------------------------
module wbps_cell (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift_en,
	input  logic       clear,
	input  logic [7:0] d_in,
	input  logic [7:0] pat,
	input  logic       wild,
	input  logic       active,
	output logic [7:0] q,
	output logic       hit
);
	logic [7:0] byte_q;

	// an unused cell or a wildcard never blocks a match
	assign hit = !active || wild || (d_in == pat);
	assign q   = byte_q;

	// window byte, cleared at the end of a source
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= 8'd0;
		end else if (shift_en) begin
			if (clear) begin
				byte_q <= 8'd0;
			end else begin
				byte_q <= d_in;
			end
		end
	end

endmodule

// File: hw/rtl/wbps_outq.sv
// ---------------------------------------------------------------------------
// wbps_outq: result record queue
// Takes up to two records per cycle and hands them out one per transfer,
// so the scanner keeps taking bytes while results wait, as long as it has room for two records.
// ---------------------------------------------------------------------------
module wbps_outq (
	input  logic           clk,
	input  logic           arst_n,
	input  wbps_pkg::push_t push,
	output logic           room2,
	output logic           out_valid,
	input  logic           out_ready,
	output wbps_pkg::rec_t out_rec
);
	import wbps_pkg::*;

	rec_t                entry_q [RQ_DEPTH];
	logic [RQ_PTR_W-1:0] wr_ptr_q;
	logic [RQ_PTR_W-1:0] rd_ptr_q;
	logic [RQ_CNT_W-1:0] cnt_q;
	logic                pop;
	logic [RQ_PTR_W-1:0] wr_ptr_p1;

	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != '0);
	assign out_rec   = entry_q[rd_ptr_q];
	assign room2     = (cnt_q <= RQ_CNT_W'(RQ_DEPTH - 2));
	assign wr_ptr_p1 = wr_ptr_q + RQ_PTR_W'(1);

	// record storage
	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			entry_q[wr_ptr_q] <= push.rec0;
		end
		if (push.cnt == 2'd2) begin
			entry_q[wr_ptr_p1] <= push.rec1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + RQ_PTR_W'(push.cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + RQ_PTR_W'(1);
			end
			cnt_q <= cnt_q + RQ_CNT_W'(push.cnt) - RQ_CNT_W'(pop);
		end
	end

endmodule

// File: hw/rtl/wildcard_byte_pattern_scanner.sv
// ---------------------------------------------------------------------------
// wildcard_byte_pattern_scanner: streaming byte pattern search with wildcards
// A chain of window cells compares the newest bytes with the pattern in the
// cycle a byte is taken; hits are non-overlapping, and each source ends in
// a summary record carrying the match count.
// ---------------------------------------------------------------------------
// The records of a byte are registered in the queue when the byte is taken and offered from there in order.
// Throughput: one byte per cycle, set by the cell chain, while the queue has room for two records; a byte
// that yields a match and a summary needs two output transfers, drained by a 4-record queue.
// Reset clears the window, counters, queue and registers (pattern length 1);
// no clearing pass is needed.
module wildcard_byte_pattern_scanner (
	input  logic        clk,
	input  logic        arst_n,
	// input byte stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // end_of_source
	// result records
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [31:0] match_offset, [63:32] match_total
	output logic        m_tuser,   // record_kind
	output logic        m_tlast,   // last_of_run
	// register writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import wbps_pkg::*;

	logic [63:0]            pat_lo_q;
	logic [63:0]            pat_hi_q;
	logic [15:0]            wild_q;
	logic [4:0]             plen_q;
	logic [OFFSET_BITS-1:0] seen_q;
	logic [LEN_W-1:0]       holdoff_q;
	logic [31:0]            found_q;

	logic                   in_xfer;
	logic [LEN_W-1:0]       eff_len;
	logic [7:0]             win [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] cell_hit;
	logic [OFFSET_BITS-1:0] seen_nx;
	logic [31:0]            off_full;
	logic                   match;
	logic [31:0]            found_nx;
	logic                   room2;
	push_t                  push;
	rec_t                   out_rec;
	rec_t                   rec_match;
	rec_t                   rec_sum;

	assign cfg_ready = 1'b1;
	assign s_tready  = room2;
	assign in_xfer   = s_tvalid && s_tready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			wild_q   <= '0;
			plen_q   <= 5'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PAT_LOW:  pat_lo_q <= cfg_data;
				REG_PAT_HIGH: pat_hi_q <= cfg_data;
				REG_WILD:     wild_q   <= cfg_data[15:0];
				REG_LEN:      plen_q   <= cfg_data[4:0];
				default: begin
				end
			endcase
		end
	end

	// effective pattern length: zero acts as one, clamp to window size
	always_comb begin
		int n;
		n = int'(plen_q);
		if (n == 0) begin
			n = 1;
		end
		if (n > PATTERN_MAX) begin
			n = PATTERN_MAX;
		end
		eff_len = LEN_W'(n);
	end

	// cell chain: cell j holds byte_window[j] and checks pattern byte len-1-j
	for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
		logic [7:0] d_in;
		int         k;
		if (j == 0) begin : g_head
			assign d_in = s_tdata;
		end else begin : g_link
			assign d_in = win[j-1];
		end
		assign k = int'(eff_len) - 1 - j;
		wbps_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (in_xfer),
			.clear    (s_tlast),
			.d_in     (d_in),
			.pat      (pat_byte(pat_lo_q, pat_hi_q, k)),
			.wild     (pat_wild(wild_q, k)),
			.active   (j < int'(eff_len)),
			.q        (win[j]),
			.hit      (cell_hit[j])
		);
	end

	// match decision on the window including the new byte
	always_comb begin
		seen_nx = seen_q;
		if (seen_q != '1) begin
			seen_nx = seen_q + OFFSET_BITS'(1);
		end
		off_full = 32'(seen_nx - OFFSET_BITS'(eff_len));
		match    = (holdoff_q == '0) && (seen_nx >= OFFSET_BITS'(eff_len)) && (&cell_hit);
		found_nx = found_q;
		if (match && found_q != '1) begin
			found_nx = found_q + 32'd1;
		end
	end

	// per-source counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q    <= '0;
			holdoff_q <= '0;
			found_q   <= '0;
		end else if (in_xfer) begin
			if (s_tlast) begin
				seen_q    <= '0;
				holdoff_q <= '0;
				found_q   <= '0;
			end else begin
				seen_q  <= seen_nx;
				found_q <= found_nx;
				if (holdoff_q != '0) begin
					holdoff_q <= holdoff_q - LEN_W'(1);
				end else if (match) begin
					holdoff_q <= eff_len - LEN_W'(1);
				end
			end
		end
	end

	// records caused by this byte
	always_comb begin
		rec_match.kind   = KIND_MATCH;
		rec_match.offset = off_full;
		rec_match.total  = found_nx;
		rec_match.last   = !s_tlast;
		rec_sum.kind     = KIND_SUMMARY;
		rec_sum.offset   = 32'd0;
		rec_sum.total    = found_nx;
		rec_sum.last     = 1'b1;
		push.cnt         = 2'd0;
		push.rec0        = rec_match;
		push.rec1        = rec_sum;
		if (in_xfer) begin
			if (match && s_tlast) begin
				push.cnt = 2'd2;
			end else if (match) begin
				push.cnt = 2'd1;
			end else if (s_tlast) begin
				push.cnt  = 2'd1;
				push.rec0 = rec_sum;
			end
		end
	end

	wbps_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room2     (room2),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_rec   (out_rec)
	);

	assign m_tdata = {out_rec.total, out_rec.offset};
	assign m_tuser = out_rec.kind;
	assign m_tlast = out_rec.last;

endmodule
